@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent checks in the blur tile project.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds while reset is high.
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/sbbt_pkg.sv @@
// ---------------------------------------------------------------------------
// sbbt_pkg
// Types and constants shared by the box blur tile modules.
// ---------------------------------------------------------------------------
package sbbt_pkg;

  localparam int unsigned PIX_W   = 32;
  localparam int unsigned CH_W    = 8;
  localparam int unsigned NUM_CH  = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TILE_WIDTH  = 3'd0,
    REG_TILE_HEIGHT = 3'd1,
    REG_BLUR_RADIUS = 3'd2,
    REG_WIN_LEFT    = 3'd3,
    REG_WIN_TOP     = 3'd4,
    REG_WIN_RIGHT   = 3'd5,
    REG_WIN_BOTTOM  = 3'd6
  } cfg_reg_t;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  typedef enum logic [7:0] {
    ST_IDLE      = 8'b0000_0001,
    ST_ROW_SETUP = 8'b0000_0010,
    ST_SUM       = 8'b0000_0100,
    ST_DIV       = 8'b0000_1000,
    ST_ROW_WRITE = 8'b0001_0000,
    ST_COL_SETUP = 8'b0010_0000,
    ST_OUT       = 8'b0100_0000,
    ST_DIV_START = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

@@ design/separable_box_blur_tile.sv @@
// ---------------------------------------------------------------------------
// separable_box_blur_tile
// Separable box blur over one RGBA8 tile held in on-chip memory.
// ---------------------------------------------------------------------------
// Input requests arrive on s_axis. tuser = 0 loads the next tile pixel in
// raster order (tdata = red, green, blue, alpha from bit 0 up); a load gives
// no result. tuser = 1 fetches the next blurred pixel of the output window;
// it gives one result on m_axis, or none while the tile is incomplete or the
// window is empty.
// The first fetch after a load or register write runs the horizontal pass
// over the whole tile: per pixel setup, n memory reads, pipeline drain,
// divide and write-back, where n is the window cut to the tile (at most
// 2r+1). Each fetch then reads n words of its column through the single read
// port of the row memory and divides them in the bit-serial divider; a new
// request is taken only once its result has gone to the output register.
// s_axis_tready is high only while the sequencer is idle. A finished result
// sits in the output register; loads are still taken while it waits, and a
// further fetch computes and then holds until m_axis_tready frees the slot.
// Reset clears the counters, the fetch position and the output valid; the
// two memories are not cleared and are only read after a complete load.
// ---------------------------------------------------------------------------
module separable_box_blur_tile import sbbt_pkg::*; #(
  parameter int unsigned MAX_TILE_WIDTH  = 128,
  parameter int unsigned MAX_TILE_HEIGHT = 128,
  parameter int unsigned MAX_RADIUS      = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [31:0]           s_axis_tdata,  // in_red, in_green, in_blue, in_alpha
  input  logic                  s_axis_tuser,  // action
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_red, out_green, out_blue, out_alpha, pixel_column, pixel_row, zero pad
  output logic [47:0]           m_axis_tdata,
  output logic                  m_axis_tlast   // last_pixel
);

  localparam int unsigned MAX_DIM = (MAX_TILE_WIDTH > MAX_TILE_HEIGHT) ?
                                    MAX_TILE_WIDTH : MAX_TILE_HEIGHT;
  localparam int unsigned CW    = $clog2(MAX_DIM + 257) + 1;
  localparam int unsigned DEPTH = MAX_TILE_WIDTH * MAX_TILE_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned DW    = $clog2(2 * MAX_RADIUS + 2);
  localparam int unsigned SW    = CH_W + DW;

  // Configuration registers.
  logic [7:0] tile_width, tile_height, win_right, win_bottom;
  logic [5:0] blur_radius;
  logic [6:0] win_left, win_top;

  logic [PIX_W-1:0] tile_mem [DEPTH];
  logic [PIX_W-1:0] row_mem  [DEPTH];
  logic [PIX_W-1:0] tile_rd, row_rd;

  state_t              state;
  logic [AW:0]         load_count;
  logic [CW-1:0]       fetch_col, fetch_row;
  logic                row_done;
  logic [CW-1:0]       col, row, cur_col, cur_row;
  logic [AW-1:0]       row_base, rd_addr;
  logic [CW-1:0]       rd_step;
  logic [DW-1:0]       rd_left, denom;
  logic                rd_valid, pass_col, cur_last;
  logic [NUM_CH-1:0][SW-1:0]   acc;
  logic [NUM_CH-1:0][CH_W-1:0] quot;
  div_ctl_t            div_ctl;

  // Effective sizes after clamping.
  logic [CW-1:0] tw, th, rad, wl, wr, wt, wb, ww, wh;
  logic [2*CW-1:0] size_prod;
  logic [AW:0]     tile_size;
  logic            fetch_ok, in_acc;

  function automatic logic [CW-1:0] clamp_dim(logic [CW-1:0] v, logic [CW-1:0] maxv);
    logic [CW-1:0] res;
    if (v == '0) res = CW'(1);
    else if (v > maxv) res = maxv;
    else res = v;
    return res;
  endfunction

  function automatic logic [CW-1:0] min_c(logic [CW-1:0] a, logic [CW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  always_comb begin
    tw  = clamp_dim(CW'(tile_width), CW'(MAX_TILE_WIDTH));
    th  = clamp_dim(CW'(tile_height), CW'(MAX_TILE_HEIGHT));
    rad = clamp_dim(CW'(blur_radius), CW'(MAX_RADIUS));
    wl  = min_c(CW'(win_left), tw);
    wr  = min_c(CW'(win_right), tw);
    wt  = min_c(CW'(win_top), th);
    wb  = min_c(CW'(win_bottom), th);
    ww  = wr - wl;
    wh  = wb - wt;
    size_prod = tw * th;
    tile_size = size_prod[AW:0];
    fetch_ok  = (load_count >= tile_size) && (wl < wr) && (wt < wb);
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Horizontal window bounds for the current column; vertical bounds and read address for the fetch.
  logic [CW-1:0] h_beg, h_end, v_beg, v_end, c_pos, r_pos;
  logic [2*CW-1:0] v_addr;
  always_comb begin
    h_beg  = (col > rad) ? col - rad : '0;
    h_end  = min_c(tw, col + rad + CW'(1));
    c_pos  = wl + fetch_col;
    r_pos  = wt + fetch_row;
    v_beg  = (r_pos > rad) ? r_pos - rad : '0;
    v_end  = min_c(th, r_pos + rad + CW'(1));
    v_addr = v_beg * tw + (2*CW)'(c_pos);
  end

  // Memories: tile written on load, row pass written by the sequencer.
  always_ff @(posedge clk) begin
    if (in_acc && s_axis_tuser == ACT_LOAD) begin
      tile_mem[(load_count >= tile_size) ? '0 : load_count[AW-1:0]] <= s_axis_tdata;
    end
    if (state == ST_ROW_WRITE) begin
      row_mem[row_base + AW'(col)] <= quot;
    end
    tile_rd <= tile_mem[rd_addr];
    row_rd  <= row_mem[rd_addr];
  end

  sbbt_div #(.SW(SW), .DW(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_ctl.start),
    .dividend (acc),
    .divisor  (denom),
    .done     (div_ctl.done),
    .quotient (quot)
  );

  assign div_ctl.start = (state == ST_DIV_START);

  always_ff @(posedge clk) begin
    logic [PIX_W-1:0] rd_word;
    rd_word = pass_col ? row_rd : tile_rd;
    if (rst) begin
      state         <= ST_IDLE;
      load_count    <= '0;
      fetch_col     <= '0;
      fetch_row     <= '0;
      row_done      <= 1'b0;
      rd_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
      tile_width    <= 8'd1;
      tile_height   <= 8'd1;
      blur_radius   <= 6'd1;
      win_left      <= '0;
      win_top       <= '0;
      win_right     <= 8'd1;
      win_bottom    <= 8'd1;
    end else begin
      // The output state refills the slot itself when it is freed.
      if (m_axis_tvalid && m_axis_tready && state != ST_OUT) m_axis_tvalid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (s_axis_tuser == ACT_LOAD) begin
              load_count <= (load_count >= tile_size) ? (AW+1)'(1) : load_count + 1'b1;
              row_done   <= 1'b0;
              fetch_col  <= '0;
              fetch_row  <= '0;
            end else if (fetch_ok) begin
              if (fetch_col >= ww || fetch_row >= wh) begin
                fetch_col <= '0;
                fetch_row <= '0;
              end
              if (row_done) begin
                state <= ST_COL_SETUP;
              end else begin
                row      <= '0;
                col      <= '0;
                row_base <= '0;
                state    <= ST_ROW_SETUP;
              end
            end
          end else if (cfg_we) begin
            case (cfg_index)
              REG_TILE_WIDTH:  tile_width  <= cfg_data;
              REG_TILE_HEIGHT: tile_height <= cfg_data;
              REG_BLUR_RADIUS: blur_radius <= cfg_data[5:0];
              REG_WIN_LEFT:    win_left    <= cfg_data[6:0];
              REG_WIN_TOP:     win_top     <= cfg_data[6:0];
              REG_WIN_RIGHT:   win_right   <= cfg_data;
              REG_WIN_BOTTOM:  win_bottom  <= cfg_data;
              default: ;
            endcase
            if (cfg_index <= REG_WIN_BOTTOM) begin
              row_done  <= 1'b0;
              fetch_col <= '0;
              fetch_row <= '0;
            end
          end
        end

        ST_ROW_SETUP: begin
          pass_col <= 1'b0;
          rd_addr  <= row_base + AW'(h_beg);
          rd_step  <= CW'(1);
          rd_left  <= DW'(h_end - h_beg);
          denom    <= DW'(h_end - h_beg);
          acc      <= '0;
          state    <= ST_SUM;
        end

        ST_COL_SETUP: begin
          pass_col <= 1'b1;
          cur_col  <= c_pos;
          cur_row  <= r_pos;
          cur_last <= (fetch_col == ww - CW'(1)) && (fetch_row == wh - CW'(1));
          rd_addr  <= v_addr[AW-1:0];
          rd_step  <= tw;
          rd_left  <= DW'(v_end - v_beg);
          denom    <= DW'(v_end - v_beg);
          acc      <= '0;
          state    <= ST_SUM;
        end

        // One memory word read per cycle, each summed in the following cycle.
        ST_SUM: begin
          rd_valid <= (rd_left != '0);
          if (rd_left != '0) begin
            rd_addr <= rd_addr + AW'(rd_step);
            rd_left <= rd_left - 1'b1;
          end
          if (rd_valid) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
              acc[ch] <= acc[ch] + SW'(rd_word[ch*CH_W +: CH_W]);
            end
          end
          if (rd_left == '0 && !rd_valid) state <= ST_DIV_START;
        end

        ST_DIV_START: state <= ST_DIV;

        ST_DIV: begin
          if (div_ctl.done) state <= pass_col ? ST_OUT : ST_ROW_WRITE;
        end

        ST_ROW_WRITE: begin
          if (col == tw - CW'(1)) begin
            col      <= '0;
            row      <= row + 1'b1;
            row_base <= row_base + AW'(tw);
            if (row == th - CW'(1)) begin
              row_done <= 1'b1;
              state    <= ST_COL_SETUP;
            end else begin
              state <= ST_ROW_SETUP;
            end
          end else begin
            col   <= col + 1'b1;
            state <= ST_ROW_SETUP;
          end
        end

        ST_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {2'b00, cur_row[6:0], cur_col[6:0], quot};
            m_axis_tlast  <= cur_last;
            if (fetch_col + CW'(1) >= ww) begin
              fetch_col <= '0;
              fetch_row <= (fetch_row + CW'(1) >= wh) ? '0 : fetch_row + CW'(1);
            end else begin
              fetch_col <= fetch_col + CW'(1);
            end
            state <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ design/sbbt_div.sv @@
// ---------------------------------------------------------------------------
// sbbt_div
// Four-lane restoring divider, one quotient bit per lane each cycle.
// ---------------------------------------------------------------------------
module sbbt_div import sbbt_pkg::*; #(
  parameter int unsigned SW = 15,
  parameter int unsigned DW = 7
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [NUM_CH-1:0][SW-1:0]        dividend,
  input  logic [DW-1:0]                    divisor,
  output logic                             done,
  output logic [NUM_CH-1:0][CH_W-1:0]      quotient
);

  localparam int unsigned CNT_W = $clog2(SW + 1);

  logic [NUM_CH-1:0][SW-1:0] dvd;
  logic [NUM_CH-1:0][DW-1:0] rem;
  logic [DW-1:0]             dsr;
  logic [CNT_W-1:0]          count;
  logic                      running;

  logic [NUM_CH-1:0][SW-1:0] dvd_next;
  logic [NUM_CH-1:0][DW-1:0] rem_next;

  always_comb begin
    logic [DW:0] sh;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sh = {rem[ch], dvd[ch][SW-1]};
      if (sh >= {1'b0, dsr}) begin
        rem_next[ch] = DW'(sh - {1'b0, dsr});
        dvd_next[ch] = {dvd[ch][SW-2:0], 1'b1};
      end else begin
        rem_next[ch] = sh[DW-1:0];
        dvd_next[ch] = {dvd[ch][SW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= CNT_W'(SW);
        dvd     <= dividend;
        rem     <= '0;
        dsr     <= divisor;
      end else if (running) begin
        dvd   <= dvd_next;
        rem   <= rem_next;
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // The averages never exceed a byte, so the low bits hold the full quotient.
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      quotient[ch] = dvd[ch][CH_W-1:0];
    end
  end

endmodule

@@ design/sbbt_checker.sv @@
// ---------------------------------------------------------------------------
// sbbt_checker
// Port-level checks for the box blur tile, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sbbt_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_we,
  input logic [2:0]  cfg_index,
  input logic [7:0]  cfg_data,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // A result waiting on a stalled receiver keeps its data.
  `ASSERT_CLK_RST(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // Reset leaves no result pending.
  `ASSERT_CLK(a_reset_empty, clk, rst |=> !m_axis_tvalid, "result valid after reset")

  // A load request never makes a result appear.
  `ASSERT_CLK_RST(a_load_silent, clk, rst, s_axis_tvalid && s_axis_tready && !s_axis_tuser && !m_axis_tvalid |=> !m_axis_tvalid, "load produced a result")

  // A fetch taken while the output is empty never yields its result in the next cycle.
  `ASSERT_CLK_RST(a_fetch_busy, clk, rst, s_axis_tvalid && s_axis_tready && s_axis_tuser && !m_axis_tvalid |=> !m_axis_tvalid, "fetch finished in one cycle")

endmodule

bind separable_box_blur_tile sbbt_checker u_sbbt_checker (.*);

@@ verif/tb_separable_box_blur_tile.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_separable_box_blur_tile
// Self-checking bench for the separable box blur tile. Tiles of many shapes
// and window settings are loaded and fetched over the streaming ports. A
// scoreboard predicts every blurred pixel and compares it with the result
// stream. Both stream sides idle and stall at random.
// ---------------------------------------------------------------------------
module tb_separable_box_blur_tile;
  import sbbt_pkg::*;

  typedef struct {
    logic [7:0] red, green, blue, alpha;
    logic [6:0] column, row;
    logic       last;
  } blur_pixel_t;

  class blur_scoreboard;
    logic [31:0] tile_mem [16384];
    logic [31:0] hpass_mem [16384];
    int unsigned load_count, fetch_col, fetch_row;
    bit          hpass_valid;
    int unsigned reg_tw, reg_th, reg_rad, reg_left, reg_top, reg_right, reg_bottom;
    blur_pixel_t pending_pixels [$];
    int unsigned mismatches, results, loads, fetches;

    function new();
      load_count = 0; fetch_col = 0; fetch_row = 0; hpass_valid = 0;
      reg_tw = 1; reg_th = 1; reg_rad = 1;
      reg_left = 0; reg_top = 0; reg_right = 1; reg_bottom = 1;
      mismatches = 0; results = 0; loads = 0; fetches = 0;
    endfunction

    function int unsigned clamp_dim(int unsigned v, int unsigned maxv);
      if (v == 0) return 1;
      return (v > maxv) ? maxv : v;
    endfunction

    function int unsigned eff_w(); return clamp_dim(reg_tw, 128); endfunction
    function int unsigned eff_h(); return clamp_dim(reg_th, 128); endfunction
    function int unsigned eff_r(); return clamp_dim(reg_rad, 32); endfunction

    function void write_reg(cfg_reg_t idx, logic [7:0] v);
      case (idx)
        REG_TILE_WIDTH:  reg_tw = v;
        REG_TILE_HEIGHT: reg_th = v;
        REG_BLUR_RADIUS: reg_rad = v & 8'h3f;
        REG_WIN_LEFT:    reg_left = v & 8'h7f;
        REG_WIN_TOP:     reg_top = v & 8'h7f;
        REG_WIN_RIGHT:   reg_right = v;
        REG_WIN_BOTTOM:  reg_bottom = v;
        default: return;
      endcase
      hpass_valid = 0; fetch_col = 0; fetch_row = 0;
    endfunction

    function void horizontal_pass(int unsigned tw, int unsigned th, int unsigned r);
      int unsigned b, e, sum;
      logic [31:0] packed_px;
      for (int unsigned y = 0; y < th; y++) begin
        for (int unsigned x = 0; x < tw; x++) begin
          b = (x > r) ? x - r : 0;
          e = (x + r + 1 < tw) ? x + r + 1 : tw;
          for (int ch = 0; ch < 4; ch++) begin
            sum = 0;
            for (int unsigned i = b; i < e; i++) sum += tile_mem[y*tw+i][8*ch +: 8];
            packed_px[8*ch +: 8] = 8'(sum / (e - b));
          end
          hpass_mem[y*tw+x] = packed_px;
        end
      end
    endfunction

    function void take_request(logic act, logic [31:0] data);
      int unsigned tw, th, r, wl, wr, wt, wb, ww, wh, c, y, b, e, sum;
      blur_pixel_t px;
      tw = eff_w(); th = eff_h(); r = eff_r();
      if (act == ACT_LOAD) begin
        loads++;
        if (load_count >= tw*th) load_count = 0;
        tile_mem[load_count] = data;
        load_count++;
        hpass_valid = 0; fetch_col = 0; fetch_row = 0;
        return;
      end
      fetches++;
      if (load_count < tw*th) return;
      wl = (reg_left < tw) ? reg_left : tw;
      wr = (reg_right < tw) ? reg_right : tw;
      wt = (reg_top < th) ? reg_top : th;
      wb = (reg_bottom < th) ? reg_bottom : th;
      if (wl >= wr || wt >= wb) return;
      ww = wr - wl; wh = wb - wt;
      if (fetch_col >= ww || fetch_row >= wh) begin
        fetch_col = 0; fetch_row = 0;
      end
      if (!hpass_valid) begin
        horizontal_pass(tw, th, r);
        hpass_valid = 1;
      end
      c = wl + fetch_col; y = wt + fetch_row;
      b = (y > r) ? y - r : 0;
      e = (y + r + 1 < th) ? y + r + 1 : th;
      for (int ch = 0; ch < 4; ch++) begin
        sum = 0;
        for (int unsigned i = b; i < e; i++) sum += hpass_mem[i*tw+c][8*ch +: 8];
        case (ch)
          0: px.red = 8'(sum / (e - b));
          1: px.green = 8'(sum / (e - b));
          2: px.blue = 8'(sum / (e - b));
          default: px.alpha = 8'(sum / (e - b));
        endcase
      end
      px.column = 7'(c); px.row = 7'(y);
      px.last = (fetch_col == ww - 1) && (fetch_row == wh - 1);
      pending_pixels = {pending_pixels, px};
      fetch_col++;
      if (fetch_col >= ww) begin
        fetch_col = 0;
        fetch_row++;
        if (fetch_row >= wh) fetch_row = 0;
      end
    endfunction

    function void match_pixel(logic [47:0] d, logic last);
      blur_pixel_t exp_px;
      results++;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: tdata=%h tlast=%b", d, last);
        return;
      end
      exp_px = pending_pixels.pop_front();
      if (d[7:0] !== exp_px.red || d[15:8] !== exp_px.green ||
          d[23:16] !== exp_px.blue || d[31:24] !== exp_px.alpha ||
          d[38:32] !== exp_px.column || d[45:39] !== exp_px.row ||
          last !== exp_px.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pixel mismatch: exp rgba=%h %h %h %h col=%0d row=%0d last=%b, got rgba=%h %h %h %h col=%0d row=%0d last=%b",
                   exp_px.red, exp_px.green, exp_px.blue, exp_px.alpha, exp_px.column,
                   exp_px.row, exp_px.last, d[7:0], d[15:8], d[23:16], d[31:24],
                   d[38:32], d[45:39], last);
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_data;
  logic        s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready, m_axis_tlast;
  logic [47:0] m_axis_tdata;

  blur_scoreboard sb;
  bit idle_on = 1;
  bit hold_pending = 0;
  int unsigned requests_sent = 0;
  int unsigned tiles_run = 0;

  separable_box_blur_tile DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  initial begin
    sb = new();
    rst = 1'b1; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = ACT_LOAD;
    m_axis_tready = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) sb.take_request(s_axis_tuser, s_axis_tdata);
    if (!rst && m_axis_tvalid && m_axis_tready) sb.match_pixel(m_axis_tdata, m_axis_tlast);
  end

  // Result side: random ready bursts, plus a long hold-off whenever one is requested.
  initial begin
    @(negedge rst);
    forever begin
      if (hold_pending) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_pending = 0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic send_request(logic act, logic [31:0] data);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= data;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    requests_sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // Waits until every predicted pixel is out and the sequencer has gone idle.
  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_regs(logic [7:0] vals [7]);
    cfg_reg_t idx;
    for (int i = 0; i < 7; i++) begin
      idx = cfg_reg_t'(i);
      cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= vals[i];
      @(posedge clk);
      sb.write_reg(idx, vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_tile(logic [7:0] vals [7], int nload, int nfetch,
                          bit extremes, bit pressure);
    drain_block();
    write_regs(vals);
    tiles_run++;
    for (int i = 0; i < nload; i++)
      send_request(ACT_LOAD, extremes ? ((i % 2) ? 32'hffff_ffff : 32'h0) : $urandom());
    if (pressure) hold_pending = 1;
    for (int i = 0; i < nfetch; i++) send_request(ACT_FETCH, $urandom());
  endtask

  initial begin
    logic [7:0] v [7];
    int unsigned tw, th, ww, wh, wl, wt, wr, wb, sz, nload, nfetch, pick;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: single pixel, extreme bytes, radius limits, oversize window,
    // incomplete tile, empty window.
    v = '{8'd1, 8'd1, 8'd1, 8'd0, 8'd0, 8'd1, 8'd1};
    run_tile(v, 1, 2, 1, 0);
    v = '{8'd2, 8'd2, 8'd0, 8'd0, 8'd0, 8'd2, 8'd2};
    run_tile(v, 4, 5, 1, 1);
    v = '{8'd0, 8'd3, 8'd63, 8'd0, 8'd0, 8'd255, 8'd255};
    run_tile(v, 2, 1, 1, 0);
    run_tile(v, 1, 4, 1, 0);
    v = '{8'd3, 8'd2, 8'd32, 8'd2, 8'd0, 8'd1, 8'd2};
    run_tile(v, 6, 2, 0, 0);

    while (requests_sent < 900) begin
      if (requests_sent > 780) idle_on = 0;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        v[0] = 8'($urandom_range(128, 255)); v[1] = 8'($urandom_range(0, 1));
      end else if (pick < 6) begin
        v[0] = 8'($urandom_range(0, 1)); v[1] = 8'($urandom_range(128, 255));
      end else begin
        v[0] = 8'($urandom_range(0, 7)); v[1] = 8'($urandom_range(0, 7));
      end
      v[2] = 8'($urandom_range(0, 63));
      tw = sb.clamp_dim(v[0], 128); th = sb.clamp_dim(v[1], 128);
      if ($urandom_range(0, 9) == 0) begin
        v[3] = 8'($urandom()); v[4] = 8'($urandom());
        v[5] = 8'($urandom()); v[6] = 8'($urandom());
      end else begin
        v[3] = 8'($urandom_range(0, tw - 1)); v[4] = 8'($urandom_range(0, th - 1));
        v[5] = 8'($urandom_range(v[3] + 1, tw + 1));
        v[6] = 8'($urandom_range(v[4] + 1, th + 1));
      end
      sz = tw * th;
      nload = (sb.load_count >= sz) ? sz : sz - sb.load_count;
      if ($urandom_range(0, 9) == 0) nload = $urandom_range(0, nload);
      wl = (v[3] & 8'h7f) < tw ? (v[3] & 8'h7f) : tw;
      wt = (v[4] & 8'h7f) < th ? (v[4] & 8'h7f) : th;
      wr = v[5] < tw ? v[5] : tw;
      wb = v[6] < th ? v[6] : th;
      ww = (wr > wl) ? wr - wl : 0;
      wh = (wb > wt) ? wb - wt : 0;
      nfetch = ((ww * wh > 30) ? 30 : ww * wh) + $urandom_range(0, 2);
      run_tile(v, nload, nfetch, 0, tiles_run == 12);
    end

    drain_block();
    $display("Covered %0d tiles: %0d loads, %0d fetches, %0d blurred pixels checked.",
             tiles_run, sb.loads, sb.fetches, sb.results);
    if (sb.mismatches == 0 && sb.pending_pixels.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d pixels missing", sb.mismatches, sb.pending_pixels.size());
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule
